// File: rtl/mefc_pkg.sv
// shared types, codes and constants of the marker/escape frame codec
package mefc_pkg;

  // result kinds
  localparam logic [1:0] KIND_RX_BYTE = 2'd0;
  localparam logic [1:0] KIND_RX_END  = 2'd1;
  localparam logic [1:0] KIND_TX_BYTE = 2'd2;

  // input actions
  localparam logic ACT_RX = 1'b0;
  localparam logic ACT_TX = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_ESCAPE_BYTE  = 2'd2;

  // register reset values
  localparam logic [7:0] START_MARKER_RST = 8'd254;
  localparam logic [7:0] END_MARKER_RST   = 8'd255;
  localparam logic [7:0] ESCAPE_BYTE_RST  = 8'd253;

  // decoded payload limit per frame
  localparam logic [6:0] MAX_FRAME = 7'd64;

  // beat slots of one descriptor, in output order
  localparam int SLOT_START = 0;
  localparam int SLOT_COUNT = 1;
  localparam int SLOT_DATA0 = 2;
  localparam int SLOT_DATA1 = 3;
  localparam int SLOT_END   = 4;
  localparam int NUM_SLOTS  = 5;

  typedef struct packed {
    logic       action;
    logic [7:0] value;
    logic       first;
    logic       last;
    logic [7:0] tx_count;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [6:0] frame_length;
    logic [7:0] declared_count;
    logic       frame_error;
    logic       run_last;
  } result_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_byte;
  } cfg_t;

  // work descriptor passed from front to back
  typedef struct packed {
    logic [1:0]           kind;
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           data0;
    logic [7:0]           data1;
    logic [7:0]           tx_count;
    logic [6:0]           frame_length;
    logic [7:0]           declared_count;
    logic                 frame_error;
  } desc_t;

  // front to queue write side
  typedef struct packed {
    logic  push;
    desc_t desc;
  } push_t;

  // queue to back read side
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } head_t;

endpackage

// File: rtl/mefc_front.sv
// front part: accepts items, tracks the receive deframer and builds descriptors
module mefc_front (
  input  logic            clk,
  input  logic            rst,
  input  mefc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  mefc_pkg::item_t in_item,
  input  logic            q_full,
  output mefc_pkg::push_t q_push
);
  import mefc_pkg::*;

  logic       in_frame, in_frame_next;
  logic       header_pending, header_pending_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] count_byte, count_byte_next;
  logic [6:0] decoded_length, decoded_length_next;
  logic       error_seen, error_seen_next;

  logic       accept;
  logic       split;
  logic [7:0] unescaped;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign split     = in_item.value >= cfg.escape_byte;
  assign unescaped = cfg.escape_byte + in_item.value;

  // classify the item, next receive state and descriptor
  always_comb begin
    in_frame_next       = in_frame;
    header_pending_next = header_pending;
    escape_pending_next = escape_pending;
    count_byte_next     = count_byte;
    decoded_length_next = decoded_length;
    error_seen_next     = error_seen;
    q_push.push         = 1'b0;
    q_push.desc         = '0;

    if (in_item.action == ACT_TX) begin
      q_push.push                  = accept;
      q_push.desc.kind             = KIND_TX_BYTE;
      q_push.desc.slots[SLOT_START] = in_item.first;
      q_push.desc.slots[SLOT_COUNT] = in_item.first;
      q_push.desc.slots[SLOT_DATA0] = 1'b1;
      q_push.desc.slots[SLOT_DATA1] = split;
      q_push.desc.slots[SLOT_END]   = in_item.last;
      q_push.desc.data0            = split ? cfg.escape_byte : in_item.value;
      q_push.desc.data1            = in_item.value - cfg.escape_byte;
      q_push.desc.tx_count         = in_item.tx_count;
    end else if (in_item.value == cfg.start_marker) begin
      in_frame_next       = 1'b1;
      header_pending_next = 1'b1;
      escape_pending_next = 1'b0;
      count_byte_next     = '0;
      decoded_length_next = '0;
      error_seen_next     = 1'b0;
    end else if (in_item.value == cfg.end_marker) begin
      if (in_frame) begin
        q_push.push                  = accept;
        q_push.desc.kind             = KIND_RX_END;
        q_push.desc.slots[SLOT_DATA0] = 1'b1;
        q_push.desc.frame_length     = decoded_length;
        q_push.desc.declared_count   = count_byte;
        q_push.desc.frame_error      = error_seen || escape_pending;
        in_frame_next                = 1'b0;
        header_pending_next          = 1'b0;
        escape_pending_next          = 1'b0;
      end
    end else if (in_frame) begin
      if (header_pending) begin
        count_byte_next     = in_item.value;
        header_pending_next = 1'b0;
      end else if (!escape_pending && in_item.value == cfg.escape_byte) begin
        escape_pending_next = 1'b1;
      end else begin
        // payload byte, plain or after an escape
        escape_pending_next = 1'b0;
        if (decoded_length < MAX_FRAME) begin
          decoded_length_next          = decoded_length + 7'd1;
          q_push.push                  = accept;
          q_push.desc.kind             = KIND_RX_BYTE;
          q_push.desc.slots[SLOT_DATA0] = 1'b1;
          q_push.desc.data0            = escape_pending ? unescaped : in_item.value;
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end
  end

  // receive state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      header_pending <= 1'b0;
      escape_pending <= 1'b0;
      count_byte     <= '0;
      decoded_length <= '0;
      error_seen     <= 1'b0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      header_pending <= header_pending_next;
      escape_pending <= escape_pending_next;
      count_byte     <= count_byte_next;
      decoded_length <= decoded_length_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

// File: rtl/mefc_queue.sv
// short descriptor queue between front and back
module mefc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  mefc_pkg::push_t wr,
  output logic            full,
  input  logic            pop,
  output mefc_pkg::head_t head
);
  import mefc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  desc_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = count == DEPTH_C;
  assign head.valid = count != '0;
  assign head.desc  = entries[rd_ptr];
  assign do_push    = wr.push && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr.desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/mefc_back.sv
// back part: expands descriptors into result beats
module mefc_back (
  input  logic              clk,
  input  logic              rst,
  input  mefc_pkg::cfg_t    cfg,
  input  mefc_pkg::head_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mefc_pkg::result_t out_item
);
  import mefc_pkg::*;

  desc_t                cur;
  logic                 cur_valid;
  logic [NUM_SLOTS-1:0] slots;
  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] remaining;
  logic                 beat_done;
  logic                 last_beat;

  // lowest pending slot is the current beat
  assign sel       = slots & (~slots + NUM_SLOTS'(1));
  assign remaining = slots & ~sel;
  assign last_beat = remaining == '0;
  assign out_valid = cur_valid;
  assign beat_done = cur_valid && out_ready;
  assign pop       = !cur_valid || (beat_done && last_beat);

  // result beat from the current descriptor
  always_comb begin
    out_item                = '0;
    out_item.kind           = cur.kind;
    out_item.frame_length   = cur.frame_length;
    out_item.declared_count = cur.declared_count;
    out_item.frame_error    = cur.frame_error;
    out_item.run_last       = last_beat;
    if (sel[SLOT_START]) begin
      out_item.data = cfg.start_marker;
    end else if (sel[SLOT_COUNT]) begin
      out_item.data = cur.tx_count;
    end else if (sel[SLOT_DATA0]) begin
      out_item.data = cur.data0;
    end else if (sel[SLOT_DATA1]) begin
      out_item.data = cur.data1;
    end else begin
      out_item.data = cfg.end_marker;
    end
  end

  // descriptor payload
  always_ff @(posedge clk) begin
    if (pop && head.valid) begin
      cur <= head.desc;
    end
  end

  // beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      slots     <= '0;
    end else if (pop) begin
      cur_valid <= head.valid;
      slots     <= head.desc.slots;
    end else if (beat_done) begin
      slots <= remaining;
    end
  end

endmodule

// File: rtl/marker_escape_frame_codec.sv
// top level of the marker/escape frame codec with its configuration registers
//
// channel   direction  handshake                 beat
// in        input      in_valid / in_ready       item_t: action, value, first, last, tx_count
// out       output     out_valid / out_ready     result_t: kind, data, length, count, error
// cfg       input      psel/penable/pwrite       apb write/read of three 8-bit registers
//
// items are accepted back to back while the queue has room
// a receive item gives zero or one beat; a transmit item gives one to five, one per cycle while out_ready is high
// the back drains one beat per cycle while out_ready is high, so sustained rate is set by the beats per item
// reset (synchronous, high) clears the deframer, the queue and the registers to defaults
// a stalled output holds its beat; the queue absorbs FIFO_DEPTH descriptors meanwhile
module marker_escape_frame_codec #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mefc_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output mefc_pkg::result_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mefc_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [1:0] reg_index;
  push_t      q_push;
  head_t      q_head;
  logic       q_full;
  logic       q_pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.end_marker   <= END_MARKER_RST;
      cfg.escape_byte  <= ESCAPE_BYTE_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_START_MARKER: cfg.start_marker <= pwdata[7:0];
        REG_END_MARKER:   cfg.end_marker   <= pwdata[7:0];
        REG_ESCAPE_BYTE:  cfg.escape_byte  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      REG_START_MARKER: prdata = {24'd0, cfg.start_marker};
      REG_END_MARKER:   prdata = {24'd0, cfg.end_marker};
      REG_ESCAPE_BYTE:  prdata = {24'd0, cfg.escape_byte};
      default:          prdata = '0;
    endcase
  end

  mefc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  mefc_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head)
  );

  mefc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: tb/marker_escape_frame_codec_chk.sv
`timescale 1ns / 100ps
// checker for the marker/escape frame codec: predicts output beats and compares them
module marker_escape_frame_codec_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mefc_pkg::item_t   in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mefc_pkg::result_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                beats_due,
  output int                mismatches
);
  import mefc_pkg::*;

  // register copies, tracked from the configuration bus
  logic [7:0] start_mk;
  logic [7:0] end_mk;
  logic [7:0] esc_mk;

  // deframer state
  logic       rx_open;
  logic       count_due;
  logic       esc_due;
  logic       frame_bad;
  logic [7:0] hdr_count;
  logic [6:0] payload_len;

  result_t want_beats[$];
  int      errs = 0;
  int      produced;

  function automatic string beat_str(input result_t b);
    return $sformatf("kind=%0d data=%02h len=%0d count=%02h err=%b last=%b",
                     b.kind, b.data, b.frame_length, b.declared_count,
                     b.frame_error, b.run_last);
  endfunction

  task automatic add_beat(input logic [1:0] kind, input logic [7:0] data,
                          input logic [6:0] len, input logic [7:0] cnt, input logic err);
    result_t r;
    r = {kind, data, len, cnt, err, 1'b0};
    want_beats.push_back(r);
    produced++;
  endtask

  // decoded byte, dropped past the frame limit
  task automatic take_payload(input logic [7:0] b);
    if (payload_len < MAX_FRAME) begin
      payload_len++;
      add_beat(KIND_RX_BYTE, b, 7'd0, 8'd0, 1'b0);
    end else begin
      frame_bad = 1'b1;
    end
  endtask

  task automatic predict_beats(input item_t it);
    result_t r;
    produced = 0;
    if (it.action == ACT_TX) begin
      // framing and escaping of one payload byte
      if (it.first) begin
        add_beat(KIND_TX_BYTE, start_mk, 7'd0, 8'd0, 1'b0);
        add_beat(KIND_TX_BYTE, it.tx_count, 7'd0, 8'd0, 1'b0);
      end
      if (it.value >= esc_mk) begin
        add_beat(KIND_TX_BYTE, esc_mk, 7'd0, 8'd0, 1'b0);
        add_beat(KIND_TX_BYTE, it.value - esc_mk, 7'd0, 8'd0, 1'b0);
      end else begin
        add_beat(KIND_TX_BYTE, it.value, 7'd0, 8'd0, 1'b0);
      end
      if (it.last) add_beat(KIND_TX_BYTE, end_mk, 7'd0, 8'd0, 1'b0);
    end else if (it.value == start_mk) begin
      // start marker always opens a fresh frame
      rx_open     = 1'b1;
      count_due   = 1'b1;
      esc_due     = 1'b0;
      hdr_count   = 8'd0;
      payload_len = 7'd0;
      frame_bad   = 1'b0;
    end else if (it.value == end_mk) begin
      if (rx_open) begin
        add_beat(KIND_RX_END, 8'd0, payload_len, hdr_count, frame_bad | esc_due);
        rx_open   = 1'b0;
        count_due = 1'b0;
        esc_due   = 1'b0;
      end
    end else if (rx_open) begin
      if (count_due) begin
        hdr_count = it.value;
        count_due = 1'b0;
      end else if (esc_due) begin
        esc_due = 1'b0;
        take_payload(esc_mk + it.value);
      end else if (it.value == esc_mk) begin
        esc_due = 1'b1;
      end else begin
        take_payload(it.value);
      end
    end
    // flag the closing beat of this item
    if (produced > 0) begin
      r = want_beats.pop_back();
      r.run_last = 1'b1;
      want_beats.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      start_mk    = START_MARKER_RST;
      end_mk      = END_MARKER_RST;
      esc_mk      = ESCAPE_BYTE_RST;
      rx_open     = 1'b0;
      count_due   = 1'b0;
      esc_due     = 1'b0;
      frame_bad   = 1'b0;
      hdr_count   = 8'd0;
      payload_len = 7'd0;
      want_beats.delete();
    end else begin
      // output beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (want_beats.size() == 0) begin
          errs++;
          $display("%0t: unexpected beat: expected none, got %s", $time, beat_str(out_item));
        end else begin
          want = want_beats.pop_front();
          if (out_item !== want) begin
            errs++;
            $display("%0t: beat mismatch: expected %s, got %s", $time,
                     beat_str(want), beat_str(out_item));
          end
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_START_MARKER: start_mk = pwdata[7:0];
          REG_END_MARKER:   end_mk   = pwdata[7:0];
          REG_ESCAPE_BYTE:  esc_mk   = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_beats(in_item);
    end
    beats_due  <= want_beats.size();
    mismatches <= errs;
  end

endmodule

// File: tb/marker_escape_frame_codec_tb.sv
`timescale 1ns / 100ps
// testbench top for the marker/escape frame codec: stimulus, stalls and verdict
module marker_escape_frame_codec_tb;
  import mefc_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  item_t       in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = 4'd0;
  logic [31:0] pwdata    = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int beats_due;
  int mismatches;

  // idle percentages of sender and receiver
  int send_idle = 27;
  int recv_idle = 59;

  // long receiver hold-off: -1 not yet started, 0 finished
  logic hold_go   = 1'b0;
  int   hold_left = -1;

  // register values as last written
  logic [7:0] start_mk = START_MARKER_RST;
  logic [7:0] end_mk   = END_MARKER_RST;
  logic [7:0] esc_mk   = ESCAPE_BYTE_RST;

  int sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  marker_escape_frame_codec u_top (.*);

  marker_escape_frame_codec_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .beats_due  (beats_due),
    .mismatches (mismatches)
  );

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_go && hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= (hold_left < 0) ? 150 : hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // run limit
  initial begin
    #400000;
    $display("marker_escape_frame_codec_tb: done, errors");
    $finish;
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // line byte; transmit-only fields carry junk
  task automatic rx_byte(input logic [7:0] b);
    item_t it;
    it.action   = ACT_RX;
    it.value    = b;
    it.first    = 1'($urandom_range(0, 1));
    it.last     = 1'($urandom_range(0, 1));
    it.tx_count = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic tx_byte(input logic [7:0] b, input logic first, input logic last,
                         input logic [7:0] cnt);
    item_t it;
    it.action   = ACT_TX;
    it.value    = b;
    it.first    = first;
    it.last     = last;
    it.tx_count = cnt;
    send_item(it);
  endtask

  // stop offering and let every expected beat drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one apb write; psel stays up for a following write
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] v);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    wait_idle();
    reg_write(REG_START_MARKER, s);
    reg_write(REG_END_MARKER, e);
    reg_write(REG_ESCAPE_BYTE, x);
    psel     <= 1'b0;
    pwrite   <= 1'b0;
    start_mk = s;
    end_mk   = e;
    esc_mk   = x;
  endtask

  // well-formed frame with random content and some escape pairs
  task automatic rx_frame(input int len, input int esc_pct);
    logic [7:0] b;
    logic [7:0] cnt;
    rx_byte(start_mk);
    do cnt = 8'($urandom_range(0, 255)); while (cnt == start_mk || cnt == end_mk);
    rx_byte(cnt);
    repeat (len) begin
      if ($urandom_range(0, 99) < esc_pct) begin
        do b = 8'($urandom_range(0, 255)); while (b == start_mk || b == end_mk);
        rx_byte(esc_mk);
        rx_byte(b);
      end else begin
        do b = 8'($urandom_range(0, 255));
        while (b == start_mk || b == end_mk || b == esc_mk);
        rx_byte(b);
      end
    end
    rx_byte(end_mk);
  endtask

  // transmit run, values biased toward the escape boundary
  task automatic tx_run(input int n);
    logic [7:0] cnt;
    logic [7:0] b;
    cnt = ($urandom_range(0, 99) < 70) ? n[7:0] : 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: b = esc_mk;
        1: b = esc_mk - 8'd1;
        2: b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      tx_byte(b, i == 0, i == n - 1, cnt);
    end
  endtask

  // stray bytes, broken frames and odd transmit flags
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: rx_byte(start_mk);
        1: rx_byte(($urandom_range(0, 1) != 0) ? end_mk : esc_mk);
        2: rx_byte(8'($urandom_range(0, 255)));
        default: tx_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic random_phase(input int budget);
    int stop;
    int pick;
    stop = sent + budget;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        rx_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8),
                 15);
      else if (pick < 75)
        tx_run($urandom_range(1, 6));
      else
        noise_burst();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: markers outside a frame, count position, escapes, restarts
    rx_byte(8'd255);
    rx_byte(8'h41);
    rx_byte(8'd254);
    rx_byte(8'd255);
    rx_byte(8'd254);
    rx_byte(8'h03);
    rx_byte(8'h00);
    rx_byte(8'd253);
    rx_byte(8'h02);
    rx_byte(8'd253);
    rx_byte(8'h80);
    rx_byte(8'd255);
    rx_byte(8'd254);
    rx_byte(8'd254);
    rx_byte(8'h10);
    rx_byte(8'd253);
    rx_byte(8'd254);
    rx_byte(8'h01);
    rx_byte(8'h7F);
    rx_byte(8'd253);
    rx_byte(8'd255);
    // directed: transmit extremes and the escape boundary
    tx_byte(8'h00, 1'b1, 1'b1, 8'h00);
    tx_byte(8'hFF, 1'b1, 1'b1, 8'hFF);
    tx_byte(8'd253, 1'b1, 1'b0, 8'h03);
    tx_byte(8'd252, 1'b0, 1'b0, 8'h03);
    tx_byte(8'hAA, 1'b0, 1'b1, 8'h03);

    random_phase(22);
    set_config(8'd0, 8'd255, 8'd128);
    random_phase(22);

    send_idle = 59;
    recv_idle = 27;
    set_config(8'd255, 8'd0, 8'd0);
    random_phase(22);
    // start and end markers equal
    set_config(8'd7, 8'd7, 8'd1);
    random_phase(22);

    send_idle = 0;
    recv_idle = 0;
    set_config(8'h55, 8'hAA, 8'hFF);
    hold_go <= 1'b1;
    // overflow past the frame limit while the output is held off
    rx_frame(68, 10);
    random_phase(22);
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    random_phase(22);

    wait_idle();
    if (mismatches == 0 && beats_due == 0) begin
      $display("marker_escape_frame_codec_tb: done, clean");
    end else begin
      $display("marker_escape_frame_codec_tb: done, errors");
    end
    $finish;
  end

endmodule
